### rtl/dtfp_pkg.sv
// Shared types, constants and the power-of-ten table for the decimal text parser.
// Used by dtfp_front, dtfp_queue, dtfp_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dtfp_pkg;

    localparam int MAX_FRACTION_DIGITS = 13;

    localparam int CHAR_W   = 8;
    localparam int FD_W     = 4;
    localparam int DIGIT_W  = 4;
    localparam int AMT_W    = 64;
    localparam int STATUS_W = 2;
    // 10^MAX_FRACTION_DIGITS fits in POW_W bits.
    localparam int POW_W    = 44;
    // Sum of up to MAX_FRACTION_DIGITS fraction terms, each below 10^13.
    localparam int FRAC_W   = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FD_W-1:0] FD_RESET = 4'd8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEGATIVE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_DIGIT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INT,
        OP_FRAC
    } t_op;

    typedef enum logic [1:0] {
        KIND_OK,
        KIND_NEG,
        KIND_ERR
    } t_kind;

    // One classified character word passed from the front to the back.
    typedef struct packed {
        t_op               op;
        logic [DIGIT_W-1:0] dv;
        logic [FRAC_W-1:0] term;
        logic [FD_W-1:0]   fd;
        logic              scale;
        logic              last;
        t_kind             kind;
    } t_cmd;

    function automatic logic [POW_W-1:0] pow10(input logic [FD_W-1:0] e);
        logic [POW_W-1:0] p;
        unique case (e)
            4'd0:    p = 44'd1;
            4'd1:    p = 44'd10;
            4'd2:    p = 44'd100;
            4'd3:    p = 44'd1000;
            4'd4:    p = 44'd10000;
            4'd5:    p = 44'd100000;
            4'd6:    p = 44'd1000000;
            4'd7:    p = 44'd10000000;
            4'd8:    p = 44'd100000000;
            4'd9:    p = 44'd1000000000;
            4'd10:   p = 44'd10000000000;
            4'd11:   p = 44'd100000000000;
            4'd12:   p = 44'd1000000000000;
            4'd13:   p = 44'd10000000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/dtfp_front.sv
// Front end: accepts characters, runs the parse phase machine and builds command words.
// Holds the fraction_digits register. Depends on dtfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_front
    import dtfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [FD_W-1:0]   i_cfg_wdata,
    input  wire logic              i_accept,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_last_char,
    output t_cmd                   o_cmd
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_INT,
        PH_SEEK,
        PH_FRAC,
        PH_NEG,
        PH_ERR
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [FD_W-1:0]   r_frac_count, n_frac_count;
    logic              r_saw_digit, n_saw_digit;
    logic              r_neg, n_neg;
    logic [FD_W-1:0]   r_fd;

    logic              w_digit;
    logic              w_space;
    logic [DIGIT_W-1:0] w_dv;
    logic [FD_W-1:0]   w_fd_eff;
    logic [FD_W-1:0]   w_exp;
    logic [POW_W-1:0]  w_pow;

    always_comb begin
        w_digit  = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        w_space  = (i_char_code == CH_SPACE) ||
                   ((i_char_code >= CH_TAB) && (i_char_code <= CH_CR));
        w_dv     = w_digit ? DIGIT_W'(i_char_code - CH_ZERO) : '0;
        w_fd_eff = (r_fd > FD_W'(MAX_FRACTION_DIGITS)) ? FD_W'(MAX_FRACTION_DIGITS) : r_fd;
        w_exp    = w_fd_eff - r_frac_count - FD_W'(1);
        w_pow    = pow10(w_exp);

        n_phase      = r_phase;
        n_frac_count = r_frac_count;
        n_saw_digit  = r_saw_digit;
        n_neg        = r_neg;

        o_cmd       = '0;
        o_cmd.op    = OP_NONE;
        o_cmd.kind  = KIND_OK;
        o_cmd.dv    = w_dv;
        o_cmd.fd    = w_fd_eff;
        o_cmd.last  = i_last_char;

        unique case (r_phase)
            PH_LEAD, PH_SIGN: begin
                if (w_digit) begin
                    n_saw_digit = 1'b1;
                    n_phase     = PH_INT;
                    o_cmd.op    = OP_INT;
                end else if (r_phase == PH_LEAD && w_space) begin
                    n_phase = r_phase;
                end else if (r_phase == PH_LEAD && i_char_code == CH_PLUS) begin
                    n_phase = PH_SIGN;
                end else if (r_phase == PH_LEAD && i_char_code == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_NEG;
                end else begin
                    n_phase = PH_ERR;
                end
            end
            PH_INT: begin
                if (w_digit) begin
                    o_cmd.op = OP_INT;
                end else begin
                    o_cmd.scale = 1'b1;
                    n_phase     = (i_char_code == CH_DOT) ? PH_FRAC : PH_SEEK;
                end
            end
            PH_SEEK: begin
                if (i_char_code == CH_DOT) begin
                    n_phase = PH_FRAC;
                end
            end
            PH_FRAC: begin
                if (r_frac_count < w_fd_eff) begin
                    if (w_digit) begin
                        o_cmd.op   = OP_FRAC;
                        o_cmd.term = FRAC_W'(w_pow) * FRAC_W'(w_dv);
                    end
                    n_frac_count = r_frac_count + FD_W'(1);
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // An integer part still open at the last character is scaled there.
        if (i_last_char && n_phase == PH_INT) begin
            o_cmd.scale = 1'b1;
        end

        if (n_neg) begin
            o_cmd.kind = KIND_NEG;
        end else if (!n_saw_digit) begin
            o_cmd.kind = KIND_ERR;
        end else begin
            o_cmd.kind = KIND_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEAD;
            r_frac_count <= '0;
            r_saw_digit  <= 1'b0;
            r_neg        <= 1'b0;
            r_fd         <= FD_RESET;
        end else begin
            if (i_cfg_we) begin
                r_fd <= i_cfg_wdata;
            end
            if (i_accept) begin
                if (i_last_char) begin
                    r_phase      <= PH_LEAD;
                    r_frac_count <= '0;
                    r_saw_digit  <= 1'b0;
                    r_neg        <= 1'b0;
                end else begin
                    r_phase      <= n_phase;
                    r_frac_count <= n_frac_count;
                    r_saw_digit  <= n_saw_digit;
                    r_neg        <= n_neg;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/dtfp_queue.sv
// Short first-in first-out queue of command words between the front and the back.
// Depends on dtfp_pkg for the word type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_queue
    import dtfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        o_data  = r_mem[r_rd_ptr];
        o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
        o_empty = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/dtfp_back.sv
// Back end: accumulates integer and fraction parts, then scales and sums in a pipeline.
// Holds the output register. Depends on dtfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_back
    import dtfp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire logic                i_empty,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [AMT_W-1:0]         o_amount_value,
    output logic [STATUS_W-1:0]      o_parse_status
);

    localparam int HALF_W  = AMT_W / 2;
    localparam int PLO_W   = POW_W / 2;
    localparam int PHI_W   = POW_W - PLO_W;
    localparam int PP_W    = HALF_W + PHI_W;
    localparam int PART_W  = PP_W + PLO_W + 1;
    localparam int PROD_W  = AMT_W + POW_W;
    localparam int WIDE_W  = PART_W + HALF_W;
    localparam int MUL10_W = AMT_W + 4;

    logic                w_adv;
    logic                w_pop;
    logic [MUL10_W-1:0]  w_mul10;
    logic [AMT_W-1:0]    n_int;
    logic                n_ovf;
    logic [FRAC_W-1:0]   n_frac;
    logic [POW_W-1:0]    n_pow;
    logic [WIDE_W-1:0]   w_prod;
    logic [AMT_W:0]      w_sum;
    logic                w_ovf;

    logic [AMT_W-1:0]    r_acc_int;
    logic                r_acc_ovf;
    logic [FRAC_W-1:0]   r_acc_frac;
    logic [POW_W-1:0]    r_scale_pow;

    logic                r_b_valid;
    logic [AMT_W-1:0]    r_b_int;
    logic                r_b_ovf;
    logic [FRAC_W-1:0]   r_b_frac;
    logic [POW_W-1:0]    r_b_pow;
    t_kind               r_b_kind;

    logic                r_c_valid;
    logic [PP_W-1:0]     r_c_pp00, r_c_pp01, r_c_pp10, r_c_pp11;
    logic                r_c_ovf;
    logic [FRAC_W-1:0]   r_c_frac;
    t_kind               r_c_kind;

    logic                r_d_valid;
    logic [PART_W-1:0]   r_d_lo, r_d_hi;
    logic                r_d_ovf;
    logic [FRAC_W-1:0]   r_d_frac;
    t_kind               r_d_kind;

    logic                r_e_valid;
    logic [PROD_W-1:0]   r_e_prod;
    logic                r_e_ovf;
    logic [FRAC_W-1:0]   r_e_frac;
    t_kind               r_e_kind;

    logic                r_out_valid;
    logic [AMT_W-1:0]    r_out_amount;
    logic [STATUS_W-1:0] r_out_status;

    always_comb begin
        w_adv = !r_out_valid || !i_out_stall;
        w_pop = !i_empty && w_adv;
        o_pop = w_pop;

        w_mul10 = MUL10_W'({r_acc_int, 3'b000}) + MUL10_W'({r_acc_int, 1'b0}) +
                  MUL10_W'(i_cmd.dv);

        n_int  = r_acc_int;
        n_ovf  = r_acc_ovf;
        n_frac = r_acc_frac;
        n_pow  = r_scale_pow;

        unique case (i_cmd.op)
            OP_INT: begin
                if (!r_acc_ovf) begin
                    if (|w_mul10[MUL10_W-1:AMT_W]) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_int = w_mul10[AMT_W-1:0];
                    end
                end
            end
            OP_FRAC: begin
                n_frac = r_acc_frac + i_cmd.term;
            end
            default: begin
                n_int = r_acc_int;
            end
        endcase

        if (i_cmd.scale) begin
            n_pow = pow10(i_cmd.fd);
        end

        w_prod = WIDE_W'(r_d_lo) + {r_d_hi, {HALF_W{1'b0}}};
        w_sum  = (AMT_W + 1)'(r_e_prod[AMT_W-1:0]) + (AMT_W + 1)'(r_e_frac);
        w_ovf  = r_e_ovf || (|r_e_prod[PROD_W-1:AMT_W]) || w_sum[AMT_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_int   <= '0;
            r_acc_ovf   <= 1'b0;
            r_acc_frac  <= '0;
            r_scale_pow <= '0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                if (i_cmd.last) begin
                    r_acc_int  <= '0;
                    r_acc_ovf  <= 1'b0;
                    r_acc_frac <= '0;
                end else begin
                    r_acc_int  <= n_int;
                    r_acc_ovf  <= n_ovf;
                    r_acc_frac <= n_frac;
                end
                r_scale_pow <= n_pow;
            end
            if (w_adv) begin
                r_b_valid <= w_pop && i_cmd.last;
                if (w_pop && i_cmd.last) begin
                    r_b_int  <= n_int;
                    r_b_ovf  <= n_ovf;
                    r_b_frac <= n_frac;
                    r_b_pow  <= n_pow;
                    r_b_kind <= i_cmd.kind;
                end

                r_c_valid <= r_b_valid;
                r_c_pp00  <= PP_W'(r_b_int[HALF_W-1:0]) * PP_W'(r_b_pow[PLO_W-1:0]);
                r_c_pp01  <= PP_W'(r_b_int[HALF_W-1:0]) * PP_W'(r_b_pow[POW_W-1:PLO_W]);
                r_c_pp10  <= PP_W'(r_b_int[AMT_W-1:HALF_W]) * PP_W'(r_b_pow[PLO_W-1:0]);
                r_c_pp11  <= PP_W'(r_b_int[AMT_W-1:HALF_W]) * PP_W'(r_b_pow[POW_W-1:PLO_W]);
                r_c_ovf   <= r_b_ovf;
                r_c_frac  <= r_b_frac;
                r_c_kind  <= r_b_kind;

                r_d_valid <= r_c_valid;
                r_d_lo    <= PART_W'(r_c_pp00) + PART_W'({r_c_pp01, {PLO_W{1'b0}}});
                r_d_hi    <= PART_W'(r_c_pp10) + PART_W'({r_c_pp11, {PLO_W{1'b0}}});
                r_d_ovf   <= r_c_ovf;
                r_d_frac  <= r_c_frac;
                r_d_kind  <= r_c_kind;

                r_e_valid <= r_d_valid;
                r_e_prod  <= w_prod[PROD_W-1:0];
                r_e_ovf   <= r_d_ovf;
                r_e_frac  <= r_d_frac;
                r_e_kind  <= r_d_kind;

                r_out_valid <= r_e_valid;
                unique case (r_e_kind)
                    KIND_NEG: begin
                        r_out_amount <= '0;
                        r_out_status <= STATUS_NEGATIVE;
                    end
                    KIND_ERR: begin
                        r_out_amount <= '0;
                        r_out_status <= STATUS_NO_DIGIT;
                    end
                    default: begin
                        if (w_ovf) begin
                            r_out_amount <= '1;
                            r_out_status <= STATUS_OVERFLOW;
                        end else begin
                            r_out_amount <= w_sum[AMT_W-1:0];
                            r_out_status <= STATUS_OK;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_out_valid    = r_out_valid;
        o_amount_value = r_out_amount;
        o_parse_status = r_out_status;
    end

endmodule

`default_nettype wire

### rtl/decimal_text_to_fixed_point.sv
// Top level of the decimal text to fixed-point parser: front, queue and back end.
// Throughput is one character word per cycle; input stalls only while the four-word queue is full.
// A result's last character word goes through the queue, stages B to E and the output register.
// The back end pipelines the integer scaling multiply over four stages after accumulation.
// Reset is synchronous, active low: it clears the parse state, the queue and the pipeline,
// and sets fraction_digits to 8. Depends on dtfp_pkg and its submodules.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_fixed_point
    import dtfp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [FD_W-1:0]     i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire logic                i_last_char,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [AMT_W-1:0]         o_amount_value,
    output logic [STATUS_W-1:0]      o_parse_status
);

    t_cmd w_front_cmd;
    t_cmd w_head_cmd;
    logic w_accept;
    logic w_full;
    logic w_empty;
    logic w_pop;

    always_comb begin
        o_in_stall = w_full;
        w_accept   = i_in_valid && !w_full;
    end

    dtfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_cmd       (w_front_cmd)
    );

    dtfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_front_cmd),
        .i_pop   (w_pop),
        .o_data  (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    dtfp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_head_cmd),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_amount_value (o_amount_value),
        .o_parse_status (o_parse_status)
    );

endmodule

`default_nettype wire
